### rtl/awm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the anagram window matcher.
// No dependencies; awm_hist, the top level and the testbench import this package.
package awm_pkg;

   localparam int ALPHABET            = 26;
   localparam int LETTER_W            = 5;
   localparam int REQ_TYPE_W          = 2;
   localparam int HELD_W              = 7;
   localparam int DEFAULT_MAX_PATTERN = 64;

   // Request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR   = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_PATTERN = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_TEXT    = 2'd2;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] req_type;
      logic [LETTER_W-1:0]   letter;
   } awm_req_type;

   typedef struct packed {
      logic              window_match;
      logic              found;
      logic              pattern_overflow;
      logic [HELD_W-1:0] letters_held;
   } awm_rsp_type;

   // Histogram update commands for one item
   typedef struct packed {
      logic                clear_all;
      logic                pat_add;
      logic                win_empty;
      logic                win_add;
      logic                win_drop;
      logic [LETTER_W-1:0] add_letter;
      logic [LETTER_W-1:0] drop_letter;
   } hist_ctl_type;

endpackage

### rtl/awm_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module awm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/awm_hist.sv
`timescale 1ns / 1ps
// Pattern and window letter histograms, one counter pair per letter.
// Depends on awm_pkg for the alphabet size and the update command struct.
module awm_hist #(
   parameter int CW = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  awm_pkg::hist_ctl_type ctl,
   output logic                 all_eq_next
);

   import awm_pkg::*;

   logic [CW-1:0]       pat_ff [ALPHABET];
   logic [CW-1:0]       pat_in [ALPHABET];
   logic [CW-1:0]       win_ff [ALPHABET];
   logic [CW-1:0]       win_in [ALPHABET];
   logic [ALPHABET-1:0] inc;
   logic [ALPHABET-1:0] dec;
   logic [ALPHABET-1:0] eq;

   for (genvar k = 0; k < ALPHABET; k++) begin : g_letter
      assign inc[k] = ctl.win_add && (ctl.add_letter == LETTER_W'(k));
      // never take a count below zero
      assign dec[k] = ctl.win_drop && (ctl.drop_letter == LETTER_W'(k)) &&
                      (win_ff[k] != '0);

      always_comb begin
         pat_in[k] = pat_ff[k];
         if (ctl.clear_all) begin
            pat_in[k] = '0;
         end else if (ctl.pat_add && (ctl.add_letter == LETTER_W'(k))) begin
            pat_in[k] = pat_ff[k] + CW'(1);
         end

         win_in[k] = win_ff[k];
         if (ctl.clear_all || ctl.win_empty) begin
            win_in[k] = '0;
         end else if (inc[k] && !dec[k]) begin
            win_in[k] = win_ff[k] + CW'(1);
         end else if (dec[k] && !inc[k]) begin
            win_in[k] = win_ff[k] - CW'(1);
         end
      end

      assign eq[k] = (win_in[k] == pat_in[k]);

      always_ff @(posedge clock) begin
         if (reset) begin
            pat_ff[k] <= '0;
            win_ff[k] <= '0;
         end else begin
            pat_ff[k] <= pat_in[k];
            win_ff[k] <= win_in[k];
         end
      end
   end

   assign all_eq_next = &eq;

endmodule

### rtl/anagram_window_matcher_top.sv
`timescale 1ns / 1ps
// Anagram window matcher: reports when the last text letters form a
// permutation of the pattern. Depends on awm_pkg, awm_hist and awm_ram.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | awm_req_type (req_type, letter)
//   rsp     | out       | rsp_valid/rsp_stall  | awm_rsp_type (match, flags, held)
//
// One item per cycle sustained while rsp is not stalled; an item's result passes the
// input register, then the result register, before it is offered on rsp.
// The window ring is a RAM read ahead at the next oldest slot (oldest_in),
// with a bypass when that slot is written in the same cycle.
// Synchronous reset empties both pipeline registers and zeroes all counts.
// A stalled result holds; the input register still takes an item while it is empty.
module anagram_window_matcher_top #(
   parameter int MAX_PATTERN = awm_pkg::DEFAULT_MAX_PATTERN
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  awm_pkg::awm_req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output awm_pkg::awm_rsp_type rsp_data
);

   import awm_pkg::*;

   localparam int LW = $clog2(MAX_PATTERN + 1);
   localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   logic          s1_valid_ff;
   awm_req_type   s1_ff;
   logic          s1_go;
   logic          rsp_valid_ff;
   awm_rsp_type   rsp_ff;
   awm_rsp_type   rsp_in;

   logic [LW-1:0] len_ff, len_in;
   logic [LW-1:0] fill_ff, fill_in;
   logic [AW-1:0] oldest_ff, oldest_in;
   logic          found_ff, found_in;
   logic          overflow_ff, overflow_in;

   logic          letter_ok;
   logic          text_live;
   logic          window_match;
   logic          all_eq_next;
   hist_ctl_type  ctl;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [LETTER_W-1:0] ram_rd_data;
   logic                byp_valid_ff;
   logic [LETTER_W-1:0] byp_data_ff;
   logic [LETTER_W-1:0] evicted;

   // Pipeline control
   assign s1_go     = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         s1_ff <= req_data;
      end
   end

   assign letter_ok = (s1_ff.letter < LETTER_W'(ALPHABET));
   assign evicted   = byp_valid_ff ? byp_data_ff : ram_rd_data;

   always_comb begin
      len_in          = len_ff;
      fill_in         = fill_ff;
      oldest_in       = oldest_ff;
      overflow_in     = overflow_ff;
      ctl             = '0;
      ctl.add_letter  = s1_ff.letter;
      ctl.drop_letter = evicted;
      wr_en           = 1'b0;
      wr_addr         = oldest_ff;
      text_live       = 1'b0;
      if (s1_go) begin
         case (s1_ff.req_type)
            REQ_CLEAR: begin
               ctl.clear_all = 1'b1;
               len_in        = '0;
               fill_in       = '0;
               oldest_in     = '0;
               overflow_in   = 1'b0;
            end
            REQ_PATTERN: begin
               if (letter_ok) begin
                  if (len_ff >= LW'(MAX_PATTERN)) begin
                     overflow_in = 1'b1;
                  end else begin
                     len_in      = len_ff + LW'(1);
                     ctl.pat_add = 1'b1;
                  end
                  ctl.win_empty = 1'b1;
                  fill_in       = '0;
                  oldest_in     = '0;
               end
            end
            REQ_TEXT: begin
               if (letter_ok) begin
                  text_live = 1'b1;
                  if (len_ff != '0) begin
                     wr_en       = 1'b1;
                     ctl.win_add = 1'b1;
                     if (fill_ff == len_ff) begin
                        // window full: replace the oldest letter, advance the ring
                        ctl.win_drop = 1'b1;
                        wr_addr      = oldest_ff;
                        if (LW'(oldest_ff) + LW'(1) == len_ff) begin
                           oldest_in = '0;
                        end else begin
                           oldest_in = oldest_ff + AW'(1);
                        end
                     end else begin
                        wr_addr = fill_ff[AW-1:0];
                        fill_in = fill_ff + LW'(1);
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // An empty pattern matches every in-range text letter
   assign window_match = text_live &&
                         ((len_ff == '0) || (all_eq_next && (fill_in == len_ff)));

   always_comb begin
      found_in = found_ff;
      if (ctl.clear_all || ctl.win_empty) begin
         found_in = 1'b0;
      end else if (window_match) begin
         found_in = 1'b1;
      end
   end

   always_comb begin
      rsp_in.window_match     = window_match;
      rsp_in.found            = found_in;
      rsp_in.pattern_overflow = overflow_in;
      rsp_in.letters_held     = HELD_W'(fill_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         fill_ff      <= '0;
         oldest_ff    <= '0;
         found_ff     <= 1'b0;
         overflow_ff  <= 1'b0;
         byp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         fill_ff      <= fill_in;
         oldest_ff    <= oldest_in;
         found_ff     <= found_in;
         overflow_ff  <= overflow_in;
         // forward a letter written to the slot being prefetched
         byp_valid_ff <= wr_en && (wr_addr == oldest_in);
         if (!rsp_valid_ff || !rsp_stall) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
      byp_data_ff <= s1_ff.letter;
      if (s1_go) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   awm_hist #(
      .CW (LW)
   ) u_hist (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .all_eq_next (all_eq_next)
   );

   awm_ram #(
      .WIDTH (LETTER_W),
      .DEPTH (MAX_PATTERN)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (s1_ff.letter),
      .rd_addr (oldest_in),
      .rd_data (ram_rd_data)
   );

`ifndef SYNTHESIS
   a_fill_le_len: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= len_ff)
      else $error("window holds more letters than the pattern");

   a_oldest_in_range: assert property (@(posedge clock) disable iff (reset)
      (oldest_ff == '0) || (LW'(oldest_ff) < len_ff))
      else $error("oldest slot beyond pattern length");

   a_oldest_needs_full: assert property (@(posedge clock) disable iff (reset)
      (oldest_ff != '0) |-> (fill_ff == len_ff))
      else $error("ring advanced before window filled");

   a_overflow_sticky: assert property (@(posedge clock) disable iff (reset)
      (overflow_ff && !ctl.clear_all) |=> overflow_ff)
      else $error("overflow flag dropped without clear");

   a_match_sets_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.window_match) |-> rsp_ff.found)
      else $error("match reported without found flag");
`endif

endmodule

### verif/tb_anagram_window_matcher_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for anagram_window_matcher_top: directed, overflow,
// backpressure and random pattern/text sequences against an in-bench predictor.
// Depends on awm_pkg and the RTL of the block only.
module tb_anagram_window_matcher_top;
   import awm_pkg::*;

   localparam int MAX_PAT      = DEFAULT_MAX_PATTERN;
   localparam int RANDOM_ITEMS = 800;
   localparam int HOLD_CYCLES  = 200;
   localparam int CYCLE_LIMIT  = 400000;
   localparam logic [REQ_TYPE_W-1:0] REQ_UNKNOWN = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   awm_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   awm_rsp_type rsp_data;

   anagram_window_matcher_top #(.MAX_PATTERN(MAX_PAT)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #4 clock = ~clock;

   // Predictor state
   int unsigned         pat_hist [ALPHABET];
   int unsigned         win_hist [ALPHABET];
   logic [LETTER_W-1:0] win_ring [MAX_PAT];
   int unsigned         pat_len, win_fill, oldest, diff_cnt, distinct_cnt;
   bit                  found_flag, ovf_flag;

   awm_rsp_type expected_rsp_q[$];
   int          errors = 0;
   int          items_sent = 0;
   int          results_seen = 0;
   int          matches_seen = 0;
   int          cycle_count = 0;
   bit          steady = 1'b0;
   int          hold_requests = 0;
   int          holds_seen = 0;
   int          hold_left = 0;

   function automatic void clear_model();
      for (int i = 0; i < ALPHABET; i++) begin
         pat_hist[i] = 0;
         win_hist[i] = 0;
      end
      for (int i = 0; i < MAX_PAT; i++) win_ring[i] = '0;
      pat_len = 0;
      win_fill = 0;
      oldest = 0;
      diff_cnt = 0;
      distinct_cnt = 0;
      found_flag = 1'b0;
      ovf_flag = 1'b0;
   endfunction

   function automatic void empty_window();
      for (int i = 0; i < ALPHABET; i++) win_hist[i] = 0;
      win_fill = 0;
      oldest = 0;
      diff_cnt = distinct_cnt;
   endfunction

   // Move one letter count up or down and track letters that differ from the pattern.
   function automatic void slide_count(input logic [LETTER_W-1:0] l, input bit up);
      bit was_diff, now_diff;
      was_diff = win_hist[l] != pat_hist[l];
      if (up) win_hist[l]++;
      else if (win_hist[l] > 0) win_hist[l]--;
      now_diff = win_hist[l] != pat_hist[l];
      if (was_diff && !now_diff && diff_cnt > 0) diff_cnt--;
      else if (!was_diff && now_diff) diff_cnt++;
   endfunction

   function automatic awm_rsp_type predict_match(input awm_req_type item);
      awm_rsp_type r;
      bit          hit;
      int unsigned slot;
      hit = 1'b0;
      if (item.req_type == REQ_CLEAR) begin
         clear_model();
      end else if (item.req_type == REQ_PATTERN && item.letter < ALPHABET) begin
         if (pat_len >= MAX_PAT) begin
            ovf_flag = 1'b1;
         end else begin
            if (pat_hist[item.letter] == 0) distinct_cnt++;
            pat_hist[item.letter]++;
            pat_len++;
         end
         empty_window();
         found_flag = 1'b0;
      end else if (item.req_type == REQ_TEXT && item.letter < ALPHABET) begin
         if (pat_len == 0) begin
            hit = 1'b1;
         end else begin
            if (win_fill >= pat_len) begin
               slot = oldest % MAX_PAT;
               slide_count(win_ring[slot], 1'b0);
               win_ring[slot] = item.letter;
               oldest = (slot + 1) % pat_len;
            end else begin
               win_ring[win_fill % MAX_PAT] = item.letter;
               win_fill++;
            end
            slide_count(item.letter, 1'b1);
            hit = (diff_cnt == 0) && (win_fill == pat_len);
         end
         if (hit) found_flag = 1'b1;
      end
      r.window_match     = hit;
      r.found            = found_flag;
      r.pattern_overflow = ovf_flag;
      r.letters_held     = HELD_W'(win_fill);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("ERROR @%0t: %s got %0d expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   // Offer one item; idle first at random unless steady, then hold it until the transfer.
   task automatic send_req(input logic [REQ_TYPE_W-1:0] kind,
                           input logic [LETTER_W-1:0] letter);
      awm_req_type item;
      awm_rsp_type want;
      item.req_type = kind;
      item.letter   = letter;
      if (!steady && $urandom_range(0, 99) < 38) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 38);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      want = predict_match(item);
      expected_rsp_q.insert(expected_rsp_q.size(), want);
      items_sent++;
   endtask

   // Pause the sender until every expected result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic send_noise();
      int kind;
      kind = $urandom_range(0, 9);
      if (kind < 4) send_req(REQ_UNKNOWN, LETTER_W'($urandom_range(0, 31)));
      else if (kind < 6) send_req(REQ_TEXT, LETTER_W'($urandom_range(ALPHABET, 31)));
      else if (kind < 8) send_req(REQ_PATTERN, LETTER_W'($urandom_range(ALPHABET, 31)));
      else if (kind == 8) send_req(REQ_PATTERN, LETTER_W'($urandom_range(0, ALPHABET - 1)));
      else send_req(REQ_CLEAR, LETTER_W'($urandom_range(0, 31)));
   endtask

   // Result checker
   always @(posedge clock) begin
      awm_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (rsp_data.window_match) matches_seen++;
         if (expected_rsp_q.size() == 0) begin
            report_mismatch("unexpected result, letters_held", rsp_data.letters_held, 0);
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_data.window_match !== want.window_match)
               report_mismatch("window_match", rsp_data.window_match, want.window_match);
            if (rsp_data.found !== want.found)
               report_mismatch("found", rsp_data.found, want.found);
            if (rsp_data.pattern_overflow !== want.pattern_overflow)
               report_mismatch("pattern_overflow", rsp_data.pattern_overflow,
                               want.pattern_overflow);
            if (rsp_data.letters_held !== want.letters_held)
               report_mismatch("letters_held", rsp_data.letters_held, want.letters_held);
         end
      end
   end

   // Receiver stall; a requested hold-off is counted here.
   always @(posedge clock) begin
      if (hold_requests != holds_seen) begin
         holds_seen = hold_requests;
         hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (steady) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 38);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("anagram_window_matcher_top: mismatch");
         $finish;
      end
   end

   task automatic test_directed();
      // empty pattern matches every text letter
      send_req(REQ_TEXT, 5'd0);
      send_req(REQ_TEXT, 5'd25);
      // pattern "az"
      send_req(REQ_PATTERN, 5'd0);
      send_req(REQ_PATTERN, 5'd25);
      send_req(REQ_TEXT, 5'd25);
      send_req(REQ_TEXT, 5'd0);
      send_req(REQ_TEXT, 5'd0);
      send_req(REQ_TEXT, 5'd25);
      // out-of-range letters and unknown requests are ignored
      send_req(REQ_TEXT, 5'd26);
      send_req(REQ_TEXT, 5'd31);
      send_req(REQ_PATTERN, 5'd31);
      send_req(REQ_UNKNOWN, 5'd0);
      send_req(REQ_UNKNOWN, 5'd31);
      // a pattern letter empties the window and drops found
      send_req(REQ_PATTERN, 5'd1);
      send_req(REQ_TEXT, 5'd1);
      send_req(REQ_TEXT, 5'd25);
      send_req(REQ_TEXT, 5'd0);
      send_req(REQ_CLEAR, 5'd31);
      // repeated letter in the pattern
      send_req(REQ_PATTERN, 5'd0);
      send_req(REQ_PATTERN, 5'd0);
      send_req(REQ_TEXT, 5'd0);
      send_req(REQ_TEXT, 5'd1);
      send_req(REQ_TEXT, 5'd0);
      send_req(REQ_TEXT, 5'd0);
      send_req(REQ_CLEAR, 5'd0);
   endtask

   task automatic test_pattern_overflow();
      logic [LETTER_W-1:0] pat[$];
      int                  j;
      logic [LETTER_W-1:0] tmp;
      send_req(REQ_CLEAR, 5'd0);
      for (int i = 0; i < MAX_PAT; i++) begin
         tmp = LETTER_W'($urandom_range(0, ALPHABET - 1));
         pat.insert(pat.size(), tmp);
         send_req(REQ_PATTERN, pat[i]);
      end
      send_req(REQ_PATTERN, 5'd3);
      send_req(REQ_PATTERN, 5'd25);
      send_req(REQ_TEXT, 5'd7);
      // full-length window holding a permutation of the pattern
      for (int i = MAX_PAT - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = pat[i];
         pat[i] = pat[j];
         pat[j] = tmp;
      end
      foreach (pat[i]) send_req(REQ_TEXT, pat[i]);
      send_req(REQ_TEXT, pat[0]);
      send_req(REQ_CLEAR, 5'd0);
      send_req(REQ_TEXT, 5'd2);
   endtask

   task automatic test_backpressure();
      send_req(REQ_CLEAR, 5'd0);
      send_req(REQ_PATTERN, 5'd4);
      send_req(REQ_PATTERN, 5'd9);
      send_req(REQ_PATTERN, 5'd4);
      hold_requests++;
      steady = 1'b1;
      for (int i = 0; i < 40; i++) send_req(REQ_TEXT, LETTER_W'(($urandom_range(0, 1)) ? 4 : 9));
      steady = 1'b0;
   endtask

   task automatic test_random_sequences();
      logic [LETTER_W-1:0] pat[$];
      logic [LETTER_W-1:0] perm[$];
      logic [LETTER_W-1:0] tmp;
      int unsigned         start, done, plen, roll, base, span, reps, n, j;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         done = items_sent - start;
         steady = (done >= 400 && done < 550);
         roll = $urandom_range(0, 99);
         if (roll < 5) plen = 0;
         else if (roll < 85) plen = $urandom_range(1, 6);
         else if (roll < 96) plen = $urandom_range(7, 20);
         else if (roll < 99) plen = $urandom_range(40, MAX_PAT);
         else plen = $urandom_range(MAX_PAT + 1, MAX_PAT + 6);
         span = $urandom_range(1, ALPHABET);
         base = $urandom_range(0, ALPHABET - span);
         send_req(REQ_CLEAR, LETTER_W'($urandom_range(0, 31)));
         pat.delete();
         for (int k = 0; k < plen; k++) begin
            tmp = LETTER_W'(base + $urandom_range(0, span - 1));
            if (k < MAX_PAT) pat.insert(pat.size(), tmp);
            send_req(REQ_PATTERN, tmp);
         end
         reps = $urandom_range(1, 4);
         for (int r = 0; r < reps; r++) begin
            perm.delete();
            if (pat.size() != 0 && $urandom_range(0, 1)) begin
               perm = pat;
               for (int i = perm.size() - 1; i > 0; i--) begin
                  j = $urandom_range(0, i);
                  tmp = perm[i];
                  perm[i] = perm[j];
                  perm[j] = tmp;
               end
            end else begin
               n = pat.size() + $urandom_range(1, 5);
               for (int i = 0; i < n; i++) begin
                  tmp = LETTER_W'(base + $urandom_range(0, span - 1));
                  perm.insert(perm.size(), tmp);
               end
            end
            foreach (perm[i]) begin
               if ($urandom_range(0, 14) == 0) send_noise();
               send_req(REQ_TEXT, perm[i]);
            end
         end
      end
      steady = 1'b0;
   endtask

   initial begin
      clear_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      drain();
      test_pattern_overflow();
      drain();
      test_backpressure();
      drain();
      test_random_sequences();
      drain();
      repeat (16) @(posedge clock);
      $display("Ran directed, overflow, backpressure and random pattern/text runs:");
      $display("%0d items sent, %0d results checked, %0d window matches.",
               items_sent, results_seen, matches_seen);
      if (errors == 0) begin
         $display("anagram_window_matcher_top: match");
      end else begin
         $display("anagram_window_matcher_top: mismatch");
      end
      $finish;
   end

endmodule

### files.f
rtl/awm_pkg.sv
rtl/awm_ram.sv
rtl/awm_hist.sv
rtl/anagram_window_matcher_top.sv
verif/tb_anagram_window_matcher_top.sv
